[sv/vwsh_pkg.sv]
package vwsh_pkg;

   localparam logic [1:0] FUNC_VERTEX = 2'd0;
   localparam logic [1:0] FUNC_FACE   = 2'd1;
   localparam logic [1:0] FUNC_CLEAR  = 2'd2;

   localparam logic [1:0] KIND_VERTEX = 2'd0;
   localparam logic [1:0] KIND_FACE   = 2'd1;
   localparam logic [1:0] KIND_CLEAR  = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_COUNT = 2'd2;

   localparam logic [31:0] PRIME_X = 32'd73856093;
   localparam logic [31:0] PRIME_Y = 32'd19349663;
   localparam logic [31:0] PRIME_Z = 32'd83492791;

   localparam logic [31:0] INVERSE_CELL_RESET = 32'd65536;
   localparam int          CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-1:0] CSR_INVERSE_CELL = 3'd0;

   // classified item handed from front to back
   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] key_x;
      logic [31:0] key_y;
      logic [31:0] key_z;
      logic [11:0] corner_a;
      logic [11:0] corner_b;
      logic [11:0] corner_c;
   } job_type;

   localparam int ITEM_W = $bits(job_type);

   typedef struct packed {
      logic [1:0]  kind;
      logic [11:0] welded_index;
      logic        is_new;
      logic        face_kept;
      logic [11:0] new_a;
      logic [11:0] new_b;
      logic [11:0] new_c;
      logic [1:0]  status;
   } rsp_type;

endpackage

[sv/vertex_weld_spatial_hash_top.sv]
// Vertex welding on a quantized grid. A vertex transaction is scaled by
// inverse_cell, rounded, hashed and looked up in a linearly probed slot table;
// the answer gives the welded index and whether the vertex is new. Face
// transactions are remapped through the stored index map, clear empties the
// table. TABLE_SLOTS must be a power of two, the first probed slot being the
// low hash bits. The front end holds a vertex while it accepts it, forms and
// rounds each key product, forms and accumulates each hash product and hands it
// over, and a face or clear while it accepts and hands it over, then takes the
// next transaction. The back end reads and then compares each probed slot on the
// registered table port; a face in range takes three index map reads, a compare
// and the answer, one out of range goes straight to the answer. A clear sweeps
// the used bits one slot per cycle, as does the pass that follows reset, during
// which no transaction is taken from the front queue.
module vertex_weld_spatial_hash_top
   import vwsh_pkg::*;
#(
   parameter int MAX_VERTICES = 4096,
   parameter int TABLE_SLOTS  = 8192
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [135:0]          req_tdata,  // pos_x, pos_y, pos_z, corner_a, corner_b, corner_c
   input  logic [1:0]            req_tuser,  // func
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [55:0]           rsp_tdata,  // welded_index, is_new, face_kept, new_a, new_b,
                                             // new_c, status
   output logic [1:0]            rsp_tuser,  // kind
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);
   localparam int SW = $clog2(TABLE_SLOTS);

   logic [31:0]   inverse_cell_ff;
   logic [31:0]   pos [3];
   logic [11:0]   corner [3];
   logic          q_push, q_full, q_pop, q_empty;
   job_type       f_item, b_item;
   logic [SW-1:0] f_slot, b_slot;
   rsp_type       rsp;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_INVERSE_CELL) ? inverse_cell_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         inverse_cell_ff <= INVERSE_CELL_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == CSR_INVERSE_CELL) begin
         inverse_cell_ff <= csr_pwdata;
      end
   end

   assign pos[0]    = req_tdata[31:0];
   assign pos[1]    = req_tdata[63:32];
   assign pos[2]    = req_tdata[95:64];
   assign corner[0] = req_tdata[107:96];
   assign corner[1] = req_tdata[119:108];
   assign corner[2] = req_tdata[131:120];

   vwsh_front #(.TABLE_SLOTS(TABLE_SLOTS)) u_front (
      .clock(clock), .reset(reset), .inverse_cell(inverse_cell_ff),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_func(req_tuser),
      .in_pos(pos), .in_corner(corner),
      .q_push(q_push), .q_item(f_item), .q_slot(f_slot), .q_full(q_full)
   );

   vwsh_fifo #(.WIDTH(ITEM_W + SW), .DEPTH(4)) u_queue (
      .clock(clock), .reset(reset),
      .push(q_push), .push_data({f_slot, f_item}), .full(q_full),
      .pop(q_pop), .pop_data({b_slot, b_item}), .empty(q_empty)
   );

   vwsh_back #(.MAX_VERTICES(MAX_VERTICES), .TABLE_SLOTS(TABLE_SLOTS)) u_back (
      .clock(clock), .reset(reset),
      .q_empty(q_empty), .q_item(b_item), .q_slot(b_slot), .q_pop(q_pop),
      .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready), .rsp(rsp)
   );

   assign rsp_tuser = rsp.kind;
   assign rsp_tdata = {4'd0, rsp.status, rsp.new_c, rsp.new_b, rsp.new_a,
                       rsp.face_kept, rsp.is_new, rsp.welded_index};
endmodule

[sv/vwsh_fifo.sv]
module vwsh_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full     = (cnt_ff == CW'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         mem[wr_ff] <= push_data;
      end
   end
endmodule

[sv/vwsh_front.sv]
module vwsh_front
   import vwsh_pkg::*;
#(
   parameter int TABLE_SLOTS = 8192
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [31:0]                    inverse_cell,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [1:0]                     in_func,
   input  logic [31:0]                    in_pos [3],
   input  logic [11:0]                    in_corner [3],
   output logic                           q_push,
   output job_type                        q_item,
   output logic [$clog2(TABLE_SLOTS)-1:0] q_slot,
   input  logic                           q_full
);
   localparam int SW = $clog2(TABLE_SLOTS);

   typedef enum logic [2:0] {
      S_IDLE, S_KMUL, S_KRND, S_HMUL, S_HACC, S_PUSH
   } state_type;

   state_type    state_ff;
   logic [1:0]   func_ff;
   logic [31:0]  pos_ff [3];
   logic [11:0]  corner_ff [3];
   logic [31:0]  key_ff [3];
   logic [1:0]   ax_ff;
   logic [63:0]  prod_ff;
   logic         neg_ff;
   logic [31:0]  hprod_ff;
   logic [31:0]  hash_ff;

   logic [31:0]  pos_sel, mag_in, prime_sel, key_in;
   logic [32:0]  rnd;

   assign in_ready = (state_ff == S_IDLE);

   always_comb begin
      pos_sel = pos_ff[ax_ff];
      mag_in  = pos_sel[31] ? (32'd0 - pos_sel) : pos_sel;
      unique case (ax_ff)
         2'd0:    prime_sel = PRIME_X;
         2'd1:    prime_sel = PRIME_Y;
         default: prime_sel = PRIME_Z;
      endcase
      rnd = 33'((prod_ff + 64'h8000_0000) >> 32);
      if (!neg_ff) begin
         key_in = (rnd > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : rnd[31:0];
      end else begin
         key_in = (rnd > 33'h0_8000_0000) ? 32'h8000_0000 : (32'd0 - rnd[31:0]);
      end
   end

   assign q_push = (state_ff == S_PUSH) && !q_full;
   always_comb begin
      q_item.func     = func_ff;
      q_item.key_x    = key_ff[0];
      q_item.key_y    = key_ff[1];
      q_item.key_z    = key_ff[2];
      q_item.corner_a = corner_ff[0];
      q_item.corner_b = corner_ff[1];
      q_item.corner_c = corner_ff[2];
      // table size is a power of two, so the first slot is the low hash bits
      q_slot          = hash_ff[SW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ax_ff    <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (in_valid) begin
                  func_ff   <= in_func;
                  pos_ff    <= in_pos;
                  corner_ff <= in_corner;
                  ax_ff     <= '0;
                  key_ff    <= '{default: '0};
                  if (in_func == FUNC_VERTEX) begin
                     state_ff <= S_KMUL;
                  end else if (in_func == FUNC_FACE || in_func == FUNC_CLEAR) begin
                     state_ff <= S_PUSH;
                  end
               end
            end
            S_KMUL: begin
               prod_ff  <= 64'(mag_in) * 64'(inverse_cell);
               neg_ff   <= pos_sel[31];
               state_ff <= S_KRND;
            end
            S_KRND: begin
               key_ff[ax_ff] <= key_in;
               if (ax_ff == 2'd2) begin
                  ax_ff    <= '0;
                  state_ff <= S_HMUL;
               end else begin
                  ax_ff    <= ax_ff + 1'b1;
                  state_ff <= S_KMUL;
               end
            end
            S_HMUL: begin
               hprod_ff <= 32'(key_ff[ax_ff] * prime_sel);
               state_ff <= S_HACC;
            end
            S_HACC: begin
               hash_ff <= (ax_ff == 2'd0) ? hprod_ff : (hash_ff ^ hprod_ff);
               if (ax_ff == 2'd2) begin
                  state_ff <= S_PUSH;
               end else begin
                  ax_ff    <= ax_ff + 1'b1;
                  state_ff <= S_HMUL;
               end
            end
            S_PUSH: begin
               if (!q_full) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

[sv/vwsh_back.sv]
module vwsh_back
   import vwsh_pkg::*;
#(
   parameter int MAX_VERTICES = 4096,
   parameter int TABLE_SLOTS  = 8192
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_empty,
   input  job_type                        q_item,
   input  logic [$clog2(TABLE_SLOTS)-1:0] q_slot,
   output logic                           q_pop,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output rsp_type                        rsp
);
   localparam int SW = $clog2(TABLE_SLOTS);
   localparam int PW = $clog2(TABLE_SLOTS + 1);
   localparam int CW = $clog2(MAX_VERTICES + 1);
   localparam int AW = $clog2(MAX_VERTICES);
   localparam int EW = 96 + CW;

   typedef enum logic [2:0] {
      S_SWEEP, S_IDLE, S_VRD, S_VCMP, S_FRD, S_FCMP, S_EMIT
   } state_type;

   state_type      state_ff;
   logic [SW-1:0]  sweep_ff;
   logic           clr_ff;
   logic [CW-1:0]  seen_ff, welded_ff;
   logic [SW-1:0]  slot_ff;
   logic [PW-1:0]  probes_ff;
   job_type        item_ff;
   logic [1:0]     fc_ff;
   logic [CW-1:0]  fmap_ff [3];
   rsp_type        res_ff;
   logic           rsp_valid_ff;
   rsp_type        rsp_ff;

   // slot table, used bits apart so a sweep can clear them
   logic           used_mem [TABLE_SLOTS];
   logic [EW-1:0]  slot_mem [TABLE_SLOTS];
   logic           used_rd_ff;
   logic [EW-1:0]  slot_rd_ff;
   logic           used_we;
   logic           used_wd;
   logic [SW-1:0]  used_wa;
   logic           slot_we;

   logic [CW-1:0]  map_mem [MAX_VERTICES];
   logic [CW-1:0]  map_rd_ff;
   logic           map_we;
   logic [CW-1:0]  map_wd;
   logic [AW-1:0]  map_ra;

   logic [11:0]    corner_sel;
   logic [31:0]    corner_ext;
   logic           face_range_ok;
   logic           key_hit;
   logic [SW-1:0]  slot_next;
   logic [CW+11:0] wide_a, wide_b, wide_c, wide_w;
   rsp_type        res_start;

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign q_pop     = (state_ff == S_IDLE) && !q_empty;

   always_comb begin
      unique case (fc_ff)
         2'd0:    corner_sel = item_ff.corner_a;
         2'd1:    corner_sel = item_ff.corner_b;
         default: corner_sel = item_ff.corner_c;
      endcase
      corner_ext    = 32'(corner_sel);
      map_ra        = corner_ext[AW-1:0];
      face_range_ok = (32'(q_item.corner_a) < 32'(seen_ff))
                   && (32'(q_item.corner_b) < 32'(seen_ff))
                   && (32'(q_item.corner_c) < 32'(seen_ff));
      key_hit = (slot_rd_ff[EW-1 -: 96] == {item_ff.key_x, item_ff.key_y, item_ff.key_z});
      slot_next = (slot_ff == SW'(TABLE_SLOTS - 1)) ? '0 : slot_ff + 1'b1;
      wide_a = (CW+12)'(fmap_ff[0]);
      wide_b = (CW+12)'(fmap_ff[1]);
      wide_c = (CW+12)'(fmap_ff[2]);
      wide_w = (CW+12)'(welded_ff);
      // answer fields known when the transaction leaves the queue
      res_start = '0;
      unique case (q_item.func)
         FUNC_VERTEX: begin
            res_start.kind = KIND_VERTEX;
            if (seen_ff >= CW'(MAX_VERTICES)) begin
               res_start.status = STATUS_COUNT;
            end
         end
         FUNC_FACE: res_start.kind = KIND_FACE;
         default:   res_start.kind = KIND_CLEAR;
      endcase
   end

   always_comb begin
      used_we = 1'b0;
      used_wd = 1'b0;
      used_wa = slot_ff;
      slot_we = 1'b0;
      map_we  = 1'b0;
      map_wd  = welded_ff;
      if (state_ff == S_SWEEP) begin
         used_we = 1'b1;
         used_wa = sweep_ff;
      end else if (state_ff == S_VCMP) begin
         map_we = 1'b1;
         if (!used_rd_ff) begin
            used_we = 1'b1;
            used_wd = 1'b1;
            slot_we = 1'b1;
         end else if (key_hit) begin
            map_wd = slot_rd_ff[CW-1:0];
         end else begin
            map_we = 1'b0;
         end
      end else if (state_ff == S_VRD && probes_ff == PW'(TABLE_SLOTS)) begin
         map_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (used_we) begin
         used_mem[used_wa] <= used_wd;
      end
      if (slot_we) begin
         slot_mem[slot_ff] <= {item_ff.key_x, item_ff.key_y, item_ff.key_z, welded_ff};
      end
      used_rd_ff <= used_mem[slot_ff];
      slot_rd_ff <= slot_mem[slot_ff];
      if (map_we) begin
         map_mem[seen_ff[AW-1:0]] <= map_wd;
      end
      map_rd_ff <= map_mem[map_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         sweep_ff     <= '0;
         clr_ff       <= 1'b0;
         seen_ff      <= '0;
         welded_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == S_EMIT && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_SWEEP: begin
               if (sweep_ff == SW'(TABLE_SLOTS - 1)) begin
                  sweep_ff <= '0;
                  state_ff <= clr_ff ? S_EMIT : S_IDLE;
               end else begin
                  sweep_ff <= sweep_ff + 1'b1;
               end
            end
            S_IDLE: begin
               if (!q_empty) begin
                  item_ff   <= q_item;
                  slot_ff   <= q_slot;
                  probes_ff <= '0;
                  fc_ff     <= '0;
                  res_ff    <= res_start;
                  unique case (q_item.func)
                     FUNC_VERTEX: begin
                        if (seen_ff >= CW'(MAX_VERTICES)) begin
                           state_ff <= S_EMIT;
                        end else begin
                           state_ff <= S_VRD;
                        end
                     end
                     FUNC_FACE: begin
                        state_ff <= face_range_ok ? S_FRD : S_EMIT;
                     end
                     default: begin
                        seen_ff   <= '0;
                        welded_ff <= '0;
                        clr_ff    <= 1'b1;
                        sweep_ff  <= '0;
                        state_ff  <= S_SWEEP;
                     end
                  endcase
               end
            end
            S_VRD: begin
               if (probes_ff == PW'(TABLE_SLOTS)) begin
                  // no free slot and no match: index given without insert
                  res_ff.welded_index <= wide_w[11:0];
                  res_ff.is_new       <= 1'b1;
                  res_ff.status       <= STATUS_FULL;
                  welded_ff           <= welded_ff + 1'b1;
                  seen_ff             <= seen_ff + 1'b1;
                  state_ff            <= S_EMIT;
               end else begin
                  state_ff <= S_VCMP;
               end
            end
            S_VCMP: begin
               if (!used_rd_ff) begin
                  res_ff.welded_index <= wide_w[11:0];
                  res_ff.is_new       <= 1'b1;
                  welded_ff           <= welded_ff + 1'b1;
                  seen_ff             <= seen_ff + 1'b1;
                  state_ff            <= S_EMIT;
               end else if (key_hit) begin
                  res_ff.welded_index <= slot_rd_ff[11:0] & 12'((1 << CW) - 1);
                  seen_ff             <= seen_ff + 1'b1;
                  state_ff            <= S_EMIT;
               end else begin
                  slot_ff   <= slot_next;
                  probes_ff <= probes_ff + 1'b1;
                  state_ff  <= S_VRD;
               end
            end
            S_FRD: begin
               // map reads issue on counts 0..2, each read's data is taken on the next count
               if (fc_ff != 2'd0) begin
                  fmap_ff[fc_ff - 2'd1] <= map_rd_ff;
               end
               if (fc_ff == 2'd3) begin
                  state_ff <= S_FCMP;
               end else begin
                  fc_ff <= fc_ff + 1'b1;
               end
            end
            S_FCMP: begin
               if (fmap_ff[0] != fmap_ff[1] && fmap_ff[1] != fmap_ff[2]
                   && fmap_ff[0] != fmap_ff[2]) begin
                  res_ff.face_kept <= 1'b1;
                  res_ff.new_a     <= wide_a[11:0];
                  res_ff.new_b     <= wide_b[11:0];
                  res_ff.new_c     <= wide_c[11:0];
               end
               state_ff <= S_EMIT;
            end
            S_EMIT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_ff   <= res_ff;
                  clr_ff   <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_welded_le_seen: assert property (@(posedge clock) disable iff (reset)
      welded_ff <= seen_ff) else $error("welded count above vertex count");
   a_seen_bound: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= CW'(MAX_VERTICES)) else $error("vertex count above limit");
   a_cmp_after_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_VCMP |-> $past(state_ff) == S_VRD)
      else $error("probe compare without read");
   a_probe_bound: assert property (@(posedge clock) disable iff (reset)
      probes_ff <= PW'(TABLE_SLOTS) || state_ff == S_IDLE || state_ff == S_SWEEP)
      else $error("probe count past table size");
endmodule
